FILE: src/tvrc_pkg.sv
// Shared types and constants for the two-view reprojection check.
// Request/result payload structs, status and opcode codes, register indexes.
// No dependencies.
package tvrc_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int VAL_W            = 32;
    localparam int IDX_W            = 5;
    localparam int NUM_COEFS        = 24;
    localparam int VIEW_COEFS       = 12;
    localparam int DEPTH_W          = 31;
    localparam int CFG_IDX_W        = 1;
    // projected coordinates clamp at 2^40 in magnitude
    localparam int QUOT_CLAMP_BIT   = 40;
    // depth limit reset is 100.0, penalty is 999.0, threshold reset is 0.08
    localparam int LIMIT_RESET_INT  = 100;
    localparam int PENALTY_INT      = 999;
    localparam int THRESH_RESET_NUM = 8;
    localparam int THRESH_RESET_DEN = 100;

    typedef enum logic {
        OP_COEF  = 1'b0,
        OP_POINT = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_VIEW1_BAD = 2'd1,
        STATUS_VIEW2_BAD = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ERROR_THRESHOLD = 1'b0,
        CFG_DEPTH_LIMIT     = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        opcode_t                   opcode;
        logic [IDX_W-1:0]          coef_index;
        logic signed [VAL_W-1:0]   coef_value;
        logic signed [VAL_W-1:0]   point_x;
        logic signed [VAL_W-1:0]   point_y;
        logic signed [VAL_W-1:0]   point_z;
        logic signed [VAL_W-1:0]   point_w;
        logic signed [VAL_W-1:0]   obs1_x;
        logic signed [VAL_W-1:0]   obs1_y;
        logic signed [VAL_W-1:0]   obs2_x;
        logic signed [VAL_W-1:0]   obs2_y;
    } in_item_t;

    typedef struct packed {
        logic                      keep;
        status_t                   status;
        logic [VAL_W-1:0]          error_sum;
        logic signed [VAL_W-1:0]   out_x;
        logic signed [VAL_W-1:0]   out_y;
        logic signed [VAL_W-1:0]   out_z;
    } out_item_t;

endpackage

FILE: src/two_view_reprojection_check.sv
// Two-view reprojection check: one request per clock while item_ready is high.
// Latency is set by two long-division pipelines that retire one quotient bit per stage:
// the divide by w (33 stages) and the divide by projected depth (42 stages), plus the
// three-stage projection multiply-add and the error and output stages. item_ready falls
// only while the output skid register holds a second result. Coefficient writes are
// ordered with points: a write takes effect for every point that follows it.
// Depends on tvrc_pkg, tvrc_delay, tvrc_div and tvrc_proj.
module two_view_reprojection_check
    import tvrc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  in_item_t             item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output out_item_t            result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data
);

    localparam int EN_W  = VAL_W + FRAC_BITS;
    localparam int EQ_W  = VAL_W;
    localparam int E_LAT = EQ_W + 1;
    localparam int ROW_W = 2 * VAL_W + 1 - FRAC_BITS;
    localparam int PN_W  = ROW_W - 1 + FRAC_BITS;
    localparam int PQ_W  = QUOT_CLAMP_BIT + 1;
    localparam int P_LAT = PQ_W + 1;
    localparam int U_W   = PQ_W + 1;
    localparam int D_W   = U_W + 1;

    localparam logic signed [VAL_W-1:0] SMAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] SMIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [63:0] PEN_FULL = 64'(PENALTY_INT) << FRAC_BITS;
    localparam logic [VAL_W-1:0] PENALTY =
        (PEN_FULL > 64'hFFFF_FFFF) ? {VAL_W{1'b1}} : PEN_FULL[VAL_W-1:0];
    localparam logic [VAL_W:0] PEN_DBL = {1'b0, PENALTY} + {1'b0, PENALTY};
    localparam logic [VAL_W-1:0] PEN_SUM = PEN_DBL[VAL_W] ? {VAL_W{1'b1}} : PEN_DBL[VAL_W-1:0];
    localparam logic [VAL_W-1:0] THRESH_RESET = VAL_W'(((64'(THRESH_RESET_NUM) << FRAC_BITS)
        + 64'(THRESH_RESET_DEN / 2)) / 64'(THRESH_RESET_DEN));
    localparam logic [DEPTH_W-1:0] LIMIT_RESET = DEPTH_W'(64'(LIMIT_RESET_INT) << FRAC_BITS);
    localparam logic [PQ_W-1:0] QCLAMP = PQ_W'(64'd1 << QUOT_CLAMP_BIT);
    localparam logic [D_W-1:0] SAT_D = D_W'({VAL_W{1'b1}});

    typedef struct packed {
        logic                    valid;
        opcode_t                 op;
        logic [IDX_W-1:0]        coef_index;
        logic [VAL_W-1:0]        coef_value;
        logic [3:0][VAL_W-1:0]   obs;
        logic [2:0]              neg;
        logic [2:0]              nz;
    } eu_side_t;

    typedef struct packed {
        logic                    valid;
        opcode_t                 op;
        logic [2:0][VAL_W-1:0]   e;
        logic [3:0][VAL_W-1:0]   obs;
    } pj_side_t;

    typedef struct packed {
        logic                    valid;
        opcode_t                 op;
        logic [2:0][VAL_W-1:0]   e;
        logic [3:0][VAL_W-1:0]   obs;
        logic [1:0]              bad;
        logic [3:0]              neg;
    } dv_side_t;

    function automatic logic [VAL_W-1:0] mag32(input logic signed [VAL_W-1:0] v);
        return v[VAL_W-1] ? VAL_W'(-v) : v;
    endfunction

    // configuration registers
    logic [VAL_W-1:0]   thr_reg;
    logic [DEPTH_W-1:0] lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESH_RESET;
            lim_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_ERROR_THRESHOLD: thr_reg <= cfg_data;
                CFG_DEPTH_LIMIT:     lim_reg <= cfg_data[DEPTH_W-1:0];
            endcase
        end
    end

    // global advance: the pipeline moves unless the skid holds a result
    logic adv;
    logic skid_valid_reg;
    logic out_valid_reg;
    out_item_t out_reg;
    out_item_t skid_reg;

    assign adv        = !skid_valid_reg;
    assign item_ready = adv;

    // input stage
    logic     v0_reg;
    in_item_t item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item;
        end
    end

    // divide by w: magnitudes into the divider, signs down the side line
    logic signed [VAL_W-1:0] pcoord [3];
    logic [EN_W-1:0]         eu_num [3];
    logic [VAL_W-1:0]        wmag;
    logic [EQ_W-1:0]         equo   [3];
    logic                    eovf   [3];
    eu_side_t                eu_in;
    eu_side_t                eu_out;

    assign pcoord[0] = item_reg.point_x;
    assign pcoord[1] = item_reg.point_y;
    assign pcoord[2] = item_reg.point_z;
    assign wmag      = mag32(item_reg.point_w);

    always_comb
    begin
        eu_in.valid      = v0_reg;
        eu_in.op         = item_reg.opcode;
        eu_in.coef_index = item_reg.coef_index;
        eu_in.coef_value = item_reg.coef_value;
        eu_in.obs[0]     = item_reg.obs1_x;
        eu_in.obs[1]     = item_reg.obs1_y;
        eu_in.obs[2]     = item_reg.obs2_x;
        eu_in.obs[3]     = item_reg.obs2_y;
        for (int k = 0; k < 3; k++)
        begin
            eu_num[k]    = {mag32(pcoord[k]), {FRAC_BITS{1'b0}}};
            eu_in.neg[k] = pcoord[k][VAL_W-1] ^ item_reg.point_w[VAL_W-1];
            eu_in.nz[k]  = |pcoord[k];
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_eu_div
        tvrc_div #(
            .NUM_W (EN_W),
            .DEN_W (VAL_W),
            .Q_W   (EQ_W)
        ) u_div (
            .clk (clk),
            .adv (adv),
            .num (eu_num[k]),
            .den (wmag),
            .quo (equo[k]),
            .ovf (eovf[k])
        );
    end

    tvrc_delay #(
        .W     ($bits(eu_side_t)),
        .DEPTH (E_LAT)
    ) u_eu_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .din   (eu_in),
        .dout  (eu_out)
    );

    // Euclidean point: sign, saturation, zero numerator
    logic                    re_valid_reg;
    eu_side_t                re_reg;
    logic signed [VAL_W-1:0] e_reg  [3];
    logic signed [VAL_W-1:0] e_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (!eu_out.nz[k])
            begin
                e_next[k] = '0;
            end
            else if (eovf[k] || equo[k][EQ_W-1])
            begin
                e_next[k] = eu_out.neg[k] ? SMIN : SMAX;
            end
            else
            begin
                e_next[k] = eu_out.neg[k] ? VAL_W'(-$signed(equo[k])) : $signed(equo[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            re_reg <= eu_out;
            e_reg  <= e_next;
        end
    end

    // coefficient store, written in request order at the projection stage
    logic signed [VAL_W-1:0] coef_reg [NUM_COEFS];
    logic signed [VAL_W-1:0] c1 [VIEW_COEFS];
    logic signed [VAL_W-1:0] c2 [VIEW_COEFS];

    always_ff @(posedge clk)
    begin
        if (adv && re_valid_reg && re_reg.op == OP_COEF
            && re_reg.coef_index < IDX_W'(NUM_COEFS))
        begin
            coef_reg[re_reg.coef_index] <= re_reg.coef_value;
        end
    end

    always_comb
    begin
        for (int i = 0; i < VIEW_COEFS; i++)
        begin
            c1[i] = coef_reg[i];
            c2[i] = coef_reg[VIEW_COEFS+i];
        end
    end

    // projection through both views
    logic signed [ROW_W-1:0] row1 [3];
    logic signed [ROW_W-1:0] row2 [3];
    pj_side_t                pj_in;
    pj_side_t                pj_out;

    tvrc_proj #(
        .FRAC_BITS (FRAC_BITS),
        .ROW_W     (ROW_W)
    ) u_proj1 (
        .clk  (clk),
        .adv  (adv),
        .coef (c1),
        .e    (e_reg),
        .row  (row1)
    );

    tvrc_proj #(
        .FRAC_BITS (FRAC_BITS),
        .ROW_W     (ROW_W)
    ) u_proj2 (
        .clk  (clk),
        .adv  (adv),
        .coef (c2),
        .e    (e_reg),
        .row  (row2)
    );

    always_comb
    begin
        pj_in.valid = re_valid_reg;
        pj_in.op    = re_reg.op;
        pj_in.obs   = re_reg.obs;
        for (int k = 0; k < 3; k++)
        begin
            pj_in.e[k] = e_reg[k];
        end
    end

    tvrc_delay #(
        .W     ($bits(pj_side_t)),
        .DEPTH (3)
    ) u_pj_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .din   (pj_in),
        .dout  (pj_out)
    );

    // depth check and divide by depth
    logic signed [ROW_W-1:0] lim_ext;
    logic signed [ROW_W-1:0] prow  [4];
    logic signed [ROW_W-1:0] pdep  [4];
    logic [ROW_W-1:0]        rmag  [4];
    logic [PN_W-1:0]         pnum  [4];
    logic [DEPTH_W-1:0]      pden  [4];
    logic [PQ_W-1:0]         pquo  [4];
    logic                    povf  [4];
    dv_side_t                dv_in;
    dv_side_t                dv_out;

    assign lim_ext = $signed({{(ROW_W-DEPTH_W){1'b0}}, lim_reg});

    always_comb
    begin
        prow[0] = row1[0];
        prow[1] = row1[1];
        prow[2] = row2[0];
        prow[3] = row2[1];
        pdep[0] = row1[2];
        pdep[1] = row1[2];
        pdep[2] = row2[2];
        pdep[3] = row2[2];
        dv_in.valid = pj_out.valid;
        dv_in.op    = pj_out.op;
        dv_in.e     = pj_out.e;
        dv_in.obs   = pj_out.obs;
        dv_in.bad[0] = row1[2][ROW_W-1] || (row1[2] == '0) || (row1[2] > lim_ext);
        dv_in.bad[1] = row2[2][ROW_W-1] || (row2[2] == '0) || (row2[2] > lim_ext);
        for (int d = 0; d < 4; d++)
        begin
            rmag[d]      = prow[d][ROW_W-1] ? ROW_W'(-prow[d]) : prow[d];
            pnum[d]      = {rmag[d][ROW_W-2:0], {FRAC_BITS{1'b0}}};
            pden[d]      = pdep[d][DEPTH_W-1:0];
            dv_in.neg[d] = prow[d][ROW_W-1];
        end
    end

    for (genvar d = 0; d < 4; d++)
    begin : g_pj_div
        tvrc_div #(
            .NUM_W (PN_W),
            .DEN_W (DEPTH_W),
            .Q_W   (PQ_W)
        ) u_div (
            .clk (clk),
            .adv (adv),
            .num (pnum[d]),
            .den (pden[d]),
            .quo (pquo[d]),
            .ovf (povf[d])
        );
    end

    tvrc_delay #(
        .W     ($bits(dv_side_t)),
        .DEPTH (P_LAT)
    ) u_dv_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .din   (dv_in),
        .dout  (dv_out)
    );

    // error stages: signed coordinate, difference, magnitude, view sum
    logic                  p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    dv_side_t              p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [U_W-1:0] u_reg     [4];
    logic signed [U_W-1:0] u_next    [4];
    logic signed [D_W-1:0] diff_reg  [4];
    logic signed [D_W-1:0] diff_next [4];
    logic [D_W-2:0]        dmag_reg  [4];
    logic [D_W-2:0]        dmag_next [4];
    logic [VAL_W-1:0]      verr_reg  [2];
    logic [VAL_W-1:0]      verr_next [2];

    always_comb
    begin
        logic [PQ_W-1:0] qc;
        logic [D_W-1:0]  dm;
        logic [D_W-1:0]  s;
        for (int d = 0; d < 4; d++)
        begin
            qc           = (povf[d] || pquo[d][PQ_W-1]) ? QCLAMP : pquo[d];
            u_next[d]    = dv_out.neg[d] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
            diff_next[d] = D_W'($signed(p1_reg.obs[d])) - D_W'(u_reg[d]);
            dm           = diff_reg[d][D_W-1] ? D_W'(-diff_reg[d]) : diff_reg[d];
            dmag_next[d] = dm[D_W-2:0];
        end
        for (int v = 0; v < 2; v++)
        begin
            s            = {1'b0, dmag_reg[2*v]} + {1'b0, dmag_reg[2*v+1]};
            verr_next[v] = (s > SAT_D) ? {VAL_W{1'b1}} : s[VAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            re_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            re_valid_reg <= eu_out.valid;
            p1_valid_reg <= dv_out.valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg   <= dv_out;
            p2_reg   <= p1_reg;
            p3_reg   <= p2_reg;
            p4_reg   <= p3_reg;
            u_reg    <= u_next;
            diff_reg <= diff_next;
            dmag_reg <= dmag_next;
            verr_reg <= verr_next;
        end
    end

    // penalties, status, saturating sum, keep decision
    out_item_t      fin;
    logic           fin_valid;
    logic [VAL_W:0] sum_full;

    always_comb
    begin
        logic [VAL_W-1:0] e1;
        logic [VAL_W-1:0] e2;
        fin_valid = p4_valid_reg && (p4_reg.op == OP_POINT);
        if (p4_reg.bad[0])
        begin
            e1         = PENALTY;
            e2         = PENALTY;
            fin.status = STATUS_VIEW1_BAD;
        end
        else if (p4_reg.bad[1])
        begin
            e1         = verr_reg[0];
            e2         = PENALTY;
            fin.status = STATUS_VIEW2_BAD;
        end
        else
        begin
            e1         = verr_reg[0];
            e2         = verr_reg[1];
            fin.status = STATUS_OK;
        end
        sum_full      = {1'b0, e1} + {1'b0, e2};
        fin.error_sum = sum_full[VAL_W] ? {VAL_W{1'b1}} : sum_full[VAL_W-1:0];
        fin.keep      = (fin.error_sum < thr_reg);
        fin.out_x     = p4_reg.e[0];
        fin.out_y     = p4_reg.e[1];
        fin.out_z     = p4_reg.e[2];
    end

    // output register with one skid entry
    logic      out_valid_next;
    logic      skid_valid_next;
    out_item_t out_next;
    out_item_t skid_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (result_ready)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (fin_valid)
        begin
            if (!out_valid_reg || result_ready)
            begin
                out_next       = fin;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = fin;
                skid_valid_next = 1'b1;
            end
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the output is empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !result_ready))
        else $error("skid filled without a stalled output");

    a_view1_penalty: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_valid && fin.status == STATUS_VIEW1_BAD) |-> (fin.error_sum == PEN_SUM))
        else $error("view one bad depth did not score both penalties");

    a_coef_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && p4_valid_reg && p4_reg.op == OP_COEF && !out_valid_reg)
        |=> !out_valid_reg)
        else $error("coefficient request produced a result");
`endif

endmodule

FILE: src/tvrc_delay.sv
// Enabled shift-register delay line used to align side data with the dividers and the projection.
// Generic width and depth; no package dependency.
module tvrc_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] pipe_reg [DEPTH];

    // shift on every pipeline advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                pipe_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            pipe_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign dout = pipe_reg[DEPTH-1];

endmodule

FILE: src/tvrc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Computes the low Q_W quotient bits plus an overflow flag.
module tvrc_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32,
    parameter int Q_W   = 32
) (
    input  logic             clk,
    input  logic             adv,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo,
    output logic             ovf
);

    localparam int TOP_W = NUM_W - Q_W;
    localparam int CMP_W = (TOP_W > DEN_W) ? TOP_W : DEN_W;

    logic [DEN_W-1:0] rem_reg  [Q_W+1];
    logic [DEN_W-1:0] den_reg  [Q_W+1];
    logic [Q_W-1:0]   lo_reg   [Q_W+1];
    logic [Q_W-1:0]   quo_reg  [Q_W+1];
    logic             ovf_reg  [Q_W+1];
    logic [DEN_W-1:0] rem_next [Q_W+1];
    logic [Q_W-1:0]   lo_next  [Q_W+1];
    logic [Q_W-1:0]   quo_next [Q_W+1];
    logic             ovf_next [Q_W+1];

    logic [CMP_W-1:0] top_ext;
    logic [CMP_W-1:0] den_ext;

    assign top_ext = CMP_W'(num[NUM_W-1:Q_W]);
    assign den_ext = CMP_W'(den);

    // stage 0: overflow when quotient bits above Q_W would be set
    // stages 1..Q_W: shift in one numerator bit, compare, subtract
    always_comb
    begin
        logic [DEN_W:0] trial;
        logic           ge;
        rem_next[0] = top_ext[DEN_W-1:0];
        lo_next[0]  = num[Q_W-1:0];
        quo_next[0] = '0;
        ovf_next[0] = (top_ext >= den_ext);
        for (int k = 1; k <= Q_W; k++)
        begin
            trial       = {rem_reg[k-1], lo_reg[k-1][Q_W-1]};
            ge          = (trial >= {1'b0, den_reg[k-1]});
            rem_next[k] = ge ? DEN_W'(trial - {1'b0, den_reg[k-1]}) : trial[DEN_W-1:0];
            lo_next[k]  = {lo_reg[k-1][Q_W-2:0], 1'b0};
            quo_next[k] = {quo_reg[k-1][Q_W-2:0], ge};
            ovf_next[k] = ovf_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg[0] <= den;
            for (int k = 0; k <= Q_W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                lo_reg[k]  <= lo_next[k];
                quo_reg[k] <= quo_next[k];
                ovf_reg[k] <= ovf_next[k];
            end
            for (int k = 1; k <= Q_W; k++)
            begin
                den_reg[k] <= den_reg[k-1];
            end
        end
    end

    assign quo = quo_reg[Q_W];
    assign ovf = ovf_reg[Q_W];

endmodule

FILE: src/tvrc_proj.sv
// Three-stage projection of a Euclidean point through one 3x4 matrix.
// Depends on tvrc_pkg for value widths.
module tvrc_proj
    import tvrc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int ROW_W     = 2 * VAL_W + 1 - FRAC_BITS
) (
    input  logic                    clk,
    input  logic                    adv,
    input  logic signed [VAL_W-1:0] coef [VIEW_COEFS],
    input  logic signed [VAL_W-1:0] e    [3],
    output logic signed [ROW_W-1:0] row  [3]
);

    logic signed [2*VAL_W-1:0] prod_reg   [9];
    logic signed [VAL_W-1:0]   off_reg    [3];
    logic signed [ROW_W-1:0]   half_a_reg [3];
    logic signed [ROW_W-1:0]   half_b_reg [3];
    logic signed [ROW_W-1:0]   row_reg    [3];
    logic signed [ROW_W-1:0]   sh         [9];

    // floor of product / 2^F
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            sh[i] = ROW_W'(prod_reg[i] >>> FRAC_BITS);
        end
    end

    // stage 1 multiply, stage 2 pairwise add, stage 3 final add
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r*3+c] <= coef[r*4+c] * e[c];
                end
                off_reg[r]    <= coef[r*4+3];
                half_a_reg[r] <= sh[r*3] + sh[r*3+1];
                half_b_reg[r] <= sh[r*3+2] + ROW_W'(off_reg[r]);
                row_reg[r]    <= half_a_reg[r] + half_b_reg[r];
            end
        end
    end

    assign row = row_reg;

endmodule
